>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared clocking and reset gating for concurrent checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define STC_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define STC_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> src/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// transaction types, codes and bit counting for the toggle counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stc_pkg;

  // fixed field widths
  localparam int IDX_W     = 8;
  localparam int IDX_RANGE = 256;
  localparam int VEC_W     = 64;
  localparam int COUNT_W   = 64;
  localparam int ADDED_W   = 7;

  // operation codes
  localparam logic OP_SCALAR = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  // incoming scalar levels
  localparam logic [1:0] LVL_ZERO = 2'd0;
  localparam logic [1:0] LVL_ONE  = 2'd1;
  localparam logic [1:0] LVL_X    = 2'd2;
  localparam logic [1:0] LVL_Z    = 2'd3;

  // stored scalar history codes
  localparam logic [1:0] SC_NONE = 2'd0;
  localparam logic [1:0] SC_ZERO = 2'd1;
  localparam logic [1:0] SC_ONE  = 2'd2;

  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   signal_index;
    logic [1:0]         scalar_value;
    logic [VEC_W-1:0]   vector_value;
    logic               vector_known;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   signal_index_res;
    logic [ADDED_W-1:0] flips_added;
    logic [COUNT_W-1:0] flip_total;
  } out_item_t;

  // ones count: eight independent byte sums, then a sum of the bytes
  function automatic logic [ADDED_W-1:0] popcount64(input logic [VEC_W-1:0] val);
    logic [3:0]         part [8];
    logic [ADDED_W-1:0] sum;
    for (int g = 0; g < 8; g++) begin
      part[g] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        part[g] = part[g] + 4'(val[g*8 + b]);
      end
    end
    sum = '0;
    for (int g = 0; g < 8; g++) begin
      sum = sum + ADDED_W'(part[g]);
    end
    return sum;
  endfunction

endpackage

>>> src/stc_ram.sv
// ----------------------------------------------------------------------------
// stc_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/signal_toggle_counter.sv
// ----------------------------------------------------------------------------
// signal_toggle_counter
// a transaction passes the stage 1 registers with the ram read data, the
//   stage 2 registers and the output register before out_valid rises
// throughput: one transaction per cycle unless out_stall holds a result, set
//   by the one read and one write port of the entry ram; the two writes still
//   in flight are forwarded; a stalled result freezes the whole pipeline
// reset clears one valid flag per entry at once, no clearing pass is needed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signal_toggle_counter #(
  parameter int SIGNAL_COUNT = 256,
  parameter int VALUE_WIDTH  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output stc_pkg::out_item_t out_item
);

  import stc_pkg::*;

  localparam int DEPTH  = (SIGNAL_COUNT < IDX_RANGE) ? SIGNAL_COUNT : IDX_RANGE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic [COUNT_W-1:0]     count;
    logic [1:0]             scalar;
    logic                   seen;
    logic [VALUE_WIDTH-1:0] vec;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // pipeline control
  logic advance;
  logic in_acc;

  // stage 1: ram read data arrives
  logic                   s1_valid_r;
  logic                   s1_op_r;
  logic [IDX_W-1:0]       s1_idx_r;
  logic                   s1_inrng_r;
  logic [1:0]             s1_level_r;
  logic [VALUE_WIDTH-1:0] s1_cur_r;

  // stage 2: count update and write back
  logic                   s2_valid_r;
  logic [IDX_W-1:0]       s2_idx_r;
  logic                   s2_inrng_r;
  entry_t                 s2_entry_r;
  logic [ADDED_W-1:0]     s2_added_r;

  // last write, for the read that collided with it
  logic                   wb_valid_r;
  logic [IDX_W-1:0]       wb_idx_r;
  entry_t                 wb_entry_r;

  logic [DEPTH-1:0]       entry_valid_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic [ENTRY_W-1:0]     ram_rdata;
  logic                   ram_we;
  entry_t                 old_entry;
  entry_t                 s2_entry_nxt;
  logic [ADDED_W-1:0]     s2_added_nxt;
  entry_t                 wr_entry;
  logic [COUNT_W-1:0]     s2_total;
  logic [VALUE_WIDTH-1:0] cur_vec;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;
  assign in_acc   = in_valid && advance;

  assign cur_vec = in_item.vector_known ? in_item.vector_value[VALUE_WIDTH-1:0] : '0;

  stc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s2_idx_r[ADDR_W-1:0]),
    .wdata (wr_entry),
    .re    (in_acc),
    .raddr (in_item.signal_index[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // stage 1 entry: newest of the pending write, the last write, the ram
  always_comb begin
    old_entry = '0;
    if (s2_valid_r && s2_inrng_r && (s2_idx_r == s1_idx_r)) begin
      old_entry = wr_entry;
    end else if (wb_valid_r && (wb_idx_r == s1_idx_r)) begin
      old_entry = wb_entry_r;
    end else if (s1_inrng_r) begin
      if (entry_valid_r[s1_idx_r[ADDR_W-1:0]]) begin
        old_entry = entry_t'(ram_rdata);
      end
    end
  end

  // stage 1 history update and flips
  always_comb begin
    s2_entry_nxt = old_entry;
    s2_added_nxt = '0;
    case (s1_op_r)
      OP_SCALAR: begin
        if (s1_level_r inside {LVL_ZERO, LVL_ONE}) begin
          s2_entry_nxt.scalar = (s1_level_r == LVL_ONE) ? SC_ONE : SC_ZERO;
          if ((old_entry.scalar != SC_NONE) && (old_entry.scalar != s2_entry_nxt.scalar)) begin
            s2_added_nxt = ADDED_W'(1);
          end
        end
      end
      OP_VECTOR: begin
        if (old_entry.seen) begin
          s2_added_nxt = popcount64(VEC_W'(s1_cur_r ^ old_entry.vec));
        end
        s2_entry_nxt.vec  = s1_cur_r;
        s2_entry_nxt.seen = 1'b1;
      end
      default: begin
        s2_added_nxt = '0;
      end
    endcase
  end

  // stage 2 count add and ram write
  assign s2_total = s2_entry_r.count + COUNT_W'(s2_added_r);

  always_comb begin
    wr_entry       = s2_entry_r;
    wr_entry.count = s2_total;
  end

  assign ram_we = advance && s2_valid_r && s2_inrng_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      wb_valid_r    <= 1'b0;
      entry_valid_r <= '0;
    end else begin
      if (advance) begin
        s1_valid_r  <= in_acc;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
      if (ram_we) begin
        wb_valid_r                            <= 1'b1;
        entry_valid_r[s2_idx_r[ADDR_W-1:0]]   <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r    <= in_item.op;
      s1_idx_r   <= in_item.signal_index;
      s1_inrng_r <= int'(in_item.signal_index) < SIGNAL_COUNT;
      s1_level_r <= in_item.scalar_value;
      s1_cur_r   <= cur_vec;

      s2_idx_r   <= s1_idx_r;
      s2_inrng_r <= s1_inrng_r;
      s2_entry_r <= s2_entry_nxt;
      s2_added_r <= s2_added_nxt;

      out_item_r.signal_index_res <= s2_idx_r;
      out_item_r.flips_added      <= s2_inrng_r ? s2_added_r : '0;
      out_item_r.flip_total       <= s2_inrng_r ? s2_total : '0;
    end
    if (ram_we) begin
      wb_idx_r   <= s2_idx_r;
      wb_entry_r <= wr_entry;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> src/stc_checker.sv
// ----------------------------------------------------------------------------
// stc_checker
// port-level checks of the toggle counter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input stc_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input stc_pkg::out_item_t out_item
);

  import stc_pkg::*;

  logic               in_acc;
  logic               out_acc;
  logic [2:0]         pending_r;
  logic               prev_ok_r;
  logic [IDX_W-1:0]   prev_idx_r;
  logic [COUNT_W-1:0] prev_total_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      prev_ok_r <= 1'b0;
    end else begin
      if (in_acc && !out_acc) begin
        pending_r <= pending_r + 3'd1;
      end else if (!in_acc && out_acc) begin
        pending_r <= pending_r - 3'd1;
      end
      if (out_acc) begin
        prev_ok_r <= 1'b1;
      end
    end
  end

  // last delivered result
  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_idx_r   <= out_item.signal_index_res;
      prev_total_r <= out_item.flip_total;
    end
  end

  `STC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")
  `STC_ASSERT_IMP(a_no_extra, out_valid, pending_r != 3'd0, "result without an accepted transaction")
  `STC_ASSERT_IMP(a_in_flight, 1'b1, pending_r <= 3'd3, "more transactions in flight than stages")
  `STC_ASSERT_IMP(a_running_total, out_valid && prev_ok_r && (out_item.signal_index_res == prev_idx_r), out_item.flip_total == prev_total_r + COUNT_W'(out_item.flips_added), "running total does not follow the previous result")

endmodule

bind signal_toggle_counter stc_checker u_stc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// toggle counter testbench: scalar and vector value changes go into the
// block while a local copy of the per-entry history predicts each flip
// count. Both sides idle at random, the receiver holds off long enough to
// back up the pipeline, and every result is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import stc_pkg::*;

  localparam int PIPE_LATENCY = 3;
  localparam int SETTLE_CYCLES = 6 * PIPE_LATENCY;
  localparam int LONG_HOLD = 80;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_CHUNKS = 7;
  localparam int CHUNK_ITEMS = 250;
  localparam int BURST_ITEMS = 80;
  localparam logic [VEC_W-1:0] ALL_ONES = {VEC_W{1'b1}};

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  // idling controls shared between the stimulus and the stall driver
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit long_hold_req = 1'b0;

  int error_count = 0;
  int cycle_count = 0;

  // per-entry history kept alongside the block
  logic [VEC_W-1:0] prev_vector [IDX_RANGE];
  logic seen_vector [IDX_RANGE];
  logic [1:0] prev_level [IDX_RANGE];
  logic [COUNT_W-1:0] toggle_total [IDX_RANGE];

  // results still owed by the block, oldest first
  out_item_t pending_counts [$];

  signal_toggle_counter #(
    .SIGNAL_COUNT(IDX_RANGE),
    .VALUE_WIDTH (VEC_W)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("signal_toggle_counter verification failed");
      $finish;
    end
  end

  function automatic void clear_history();
    for (int i = 0; i < IDX_RANGE; i++) begin
      prev_vector[i] = '0;
      seen_vector[i] = 1'b0;
      prev_level[i] = SC_NONE;
      toggle_total[i] = '0;
    end
  endfunction

  // update the history for one accepted change and return the result it owes
  function automatic out_item_t apply_value_change(input in_item_t item);
    out_item_t res;
    logic [VEC_W-1:0] now_vec;
    logic [1:0] code;
    int unsigned ent;
    int unsigned flips;
    ent = 32'(item.signal_index);
    flips = 0;
    if (item.op == OP_SCALAR) begin
      // x and z leave the scalar history alone
      if (item.scalar_value == LVL_ZERO || item.scalar_value == LVL_ONE) begin
        code = (item.scalar_value == LVL_ZERO) ? SC_ZERO : SC_ONE;
        if (prev_level[ent] != SC_NONE && prev_level[ent] != code) flips = 1;
        prev_level[ent] = code;
      end
    end else begin
      // a vector with non-binary digits counts as zero
      now_vec = item.vector_known ? item.vector_value : '0;
      if (seen_vector[ent]) flips = $countones(now_vec ^ prev_vector[ent]);
      prev_vector[ent] = now_vec;
      seen_vector[ent] = 1'b1;
    end
    toggle_total[ent] = toggle_total[ent] + COUNT_W'(flips);
    res.signal_index_res = item.signal_index;
    res.flips_added = ADDED_W'(flips);
    res.flip_total = toggle_total[ent];
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  function automatic in_item_t junk_item();
    in_item_t item;
    item.op = $urandom_range(0, 1) ? OP_VECTOR : OP_SCALAR;
    item.signal_index = IDX_W'($urandom_range(0, IDX_RANGE - 1));
    item.scalar_value = 2'($urandom_range(0, 3));
    item.vector_value = {$urandom, $urandom};
    item.vector_known = 1'($urandom_range(0, 1));
    return item;
  endfunction

  function automatic in_item_t scalar_change(input logic [IDX_W-1:0] idx,
                                             input logic [1:0] lvl);
    in_item_t item;
    item = junk_item();
    item.op = OP_SCALAR;
    item.signal_index = idx;
    item.scalar_value = lvl;
    return item;
  endfunction

  function automatic in_item_t vector_change(input logic [IDX_W-1:0] idx,
                                             input logic [VEC_W-1:0] val,
                                             input logic known);
    in_item_t item;
    item = junk_item();
    item.op = OP_VECTOR;
    item.signal_index = idx;
    item.vector_value = val;
    item.vector_known = known;
    return item;
  endfunction

  // random change, biased toward a few hot entries, some with small flips
  function automatic in_item_t random_change(input logic [IDX_W-1:0] prev_idx);
    in_item_t item;
    int pick;
    logic [VEC_W-1:0] base;
    item = junk_item();
    pick = $urandom_range(0, 99);
    if (pick < 25) item.signal_index = prev_idx;
    else if (pick < 75) item.signal_index = IDX_W'($urandom_range(0, 7));
    else item.signal_index = IDX_W'($urandom_range(0, IDX_RANGE - 1));
    item.vector_known = ($urandom_range(0, 9) != 0);
    base = prev_vector[item.signal_index];
    case ($urandom_range(0, 3))
      0: item.vector_value = {$urandom, $urandom};
      1: item.vector_value = base ^ (VEC_W'(1) << $urandom_range(0, VEC_W - 1))
                                  ^ (VEC_W'(1) << $urandom_range(0, VEC_W - 1));
      2: item.vector_value = $urandom_range(0, 1) ? ALL_ONES : '0;
      default: item.vector_value = base ^ {$urandom, $urandom};
    endcase
    return item;
  endfunction

  // offer one transaction and hold it until accepted
  task automatic send_change(input in_item_t item);
    int gap;
    gap = pick_gap(tx_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_item <= junk_item();
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_counts.insert(pending_counts.size(), apply_value_change(item));
  endtask

  // stop offering and wait until every result is back
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result stall driver
  initial begin : result_stall_driver
    int run;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        run = pick_gap(rx_idle_on);
        if (run > 0) begin
          out_stall <= 1'b1;
          repeat (run) @(negedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result idx %0h added %0d total %0h", $time,
                 out_item.signal_index_res, out_item.flips_added, out_item.flip_total);
      end else begin
        want = pending_counts.pop_front();
        if (out_item.signal_index_res !== want.signal_index_res) begin
          error_count++;
          $display("%0t: signal_index_res expected %0h actual %0h", $time,
                   want.signal_index_res, out_item.signal_index_res);
        end
        if (out_item.flips_added !== want.flips_added) begin
          error_count++;
          $display("%0t: flips_added expected %0d actual %0d", $time,
                   want.flips_added, out_item.flips_added);
        end
        if (out_item.flip_total !== want.flip_total) begin
          error_count++;
          $display("%0t: flip_total expected %0h actual %0h", $time,
                   want.flip_total, out_item.flip_total);
        end
      end
    end
  end

  // levels on one entry, x and z in between, and the top entry
  task automatic test_scalar_levels();
    send_change(scalar_change(8'd0, LVL_ZERO));
    send_change(scalar_change(8'd0, LVL_ONE));
    send_change(scalar_change(8'd0, LVL_X));
    send_change(scalar_change(8'd0, LVL_Z));
    send_change(scalar_change(8'd0, LVL_ZERO));
    send_change(scalar_change(8'd0, LVL_ZERO));
    send_change(scalar_change(8'd0, LVL_ONE));
    send_change(scalar_change(8'd255, LVL_X));
    send_change(scalar_change(8'd255, LVL_ONE));
    send_change(scalar_change(8'd255, LVL_ZERO));
    wait_results_done();
  endtask

  // first vector adds nothing, then full and single-bit flips
  task automatic test_vector_changes();
    send_change(vector_change(8'd0, ALL_ONES, 1'b1));
    send_change(vector_change(8'd0, '0, 1'b1));
    send_change(vector_change(8'd0, ALL_ONES, 1'b1));
    send_change(vector_change(8'd128, {32{2'b01}}, 1'b1));
    send_change(vector_change(8'd128, {32{2'b10}}, 1'b1));
    send_change(vector_change(8'd128, {{31{2'b10}}, 2'b11}, 1'b1));
    send_change(vector_change(8'd255, {1'b1, 62'd0, 1'b1}, 1'b1));
    wait_results_done();
  endtask

  // unknown digits read as zero, also as the first vector of an entry
  task automatic test_unknown_vectors();
    send_change(vector_change(8'd128, ALL_ONES, 1'b0));
    send_change(vector_change(8'd128, '0, 1'b1));
    send_change(vector_change(8'd64, ALL_ONES, 1'b0));
    send_change(vector_change(8'd64, 64'd1, 1'b1));
    wait_results_done();
  endtask

  // receiver holds off while the sender keeps pushing
  task automatic test_back_pressure();
    logic [IDX_W-1:0] last_idx;
    in_item_t item;
    last_idx = 8'd0;
    tx_idle_on = 1'b0;
    long_hold_req = 1'b1;
    repeat (BURST_ITEMS) begin
      item = random_change(last_idx);
      send_change(item);
      last_idx = item.signal_index;
    end
    wait_results_done();
  endtask

  // random traffic in chunks with changing idle patterns
  task automatic test_random_traffic();
    logic [IDX_W-1:0] last_idx;
    in_item_t item;
    int mode;
    last_idx = 8'd0;
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      if (c == 0) mode = 0;
      else if (c == 1) mode = 3;
      else mode = $urandom_range(0, 3);
      tx_idle_on = mode[0];
      rx_idle_on = mode[1];
      repeat (CHUNK_ITEMS) begin
        item = random_change(last_idx);
        send_change(item);
        last_idx = item.signal_index;
      end
      if (c == RANDOM_CHUNKS / 2) wait_results_done();
    end
    wait_results_done();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    clear_history();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_scalar_levels();
    test_vector_changes();
    test_unknown_vectors();
    test_back_pressure();
    test_random_traffic();

    if (error_count == 0 && pending_counts.size() == 0) begin
      $display("signal_toggle_counter verification clean");
    end else begin
      $display("signal_toggle_counter verification failed");
    end
    $finish;
  end

endmodule
